>>> hw/rtl/swts_pkg.sv
// ----------------------------------------------------------------------------
// swts_pkg
// Shared types and constants for the sorted word table search block.
// ----------------------------------------------------------------------------
package swts_pkg;

    localparam int WORD_LETTERS_DEF = 5;
    localparam int TABLE_DEPTH_DEF  = 16384;

    localparam int INDEX_W = 14;
    localparam int COUNT_W = 15;

    typedef enum logic
    {
        ACT_LOAD   = 1'b0,
        ACT_LOOKUP = 1'b1
    } swts_action_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_CMP,
        ST_DONE
    } swts_state_t;

    typedef struct packed
    {
        swts_action_t kind;
        logic         addr_ok;
    } swts_cmd_ctrl_t;

endpackage

>>> hw/rtl/swts_front.sv
// ----------------------------------------------------------------------------
// swts_front
// Accepts input words, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module swts_front #(
    parameter int WORD_LETTERS = swts_pkg::WORD_LETTERS_DEF,
    parameter int TABLE_DEPTH  = swts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 action,
    input  logic [swts_pkg::INDEX_W-1:0]         entry_index,
    input  logic [8*WORD_LETTERS-1:0]            word,
    output logic                                 cmd_valid,
    output swts_pkg::swts_cmd_ctrl_t             cmd_ctrl,
    output logic [$clog2(TABLE_DEPTH)-1:0]       cmd_addr,
    output logic [8*WORD_LETTERS-1:0]            cmd_key,
    input  logic                                 cmd_pop
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int WW = 8 * WORD_LETTERS;

    swts_pkg::swts_cmd_ctrl_t q_ctrl_reg [2];
    logic [AW-1:0]            q_addr_reg [2];
    logic [WW-1:0]            q_key_reg  [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    logic                     do_push;
    logic                     do_pop;
    logic [31:0]              idx32;
    swts_pkg::swts_cmd_ctrl_t in_ctrl;

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        idx32           = 32'(entry_index);
        in_ctrl.kind    = swts_pkg::swts_action_t'(action);
        in_ctrl.addr_ok = (idx32 < 32'(TABLE_DEPTH));
    end

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_ctrl_reg[wr_ptr_reg] <= in_ctrl;
            q_addr_reg[wr_ptr_reg] <= idx32[AW-1:0];
            q_key_reg[wr_ptr_reg]  <= word;
        end
    end

    assign cmd_ctrl = q_ctrl_reg[rd_ptr_reg];
    assign cmd_addr = q_addr_reg[rd_ptr_reg];
    assign cmd_key  = q_key_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/swts_back.sv
// ----------------------------------------------------------------------------
// swts_back
// Word table memory, binary search sequencer and result register.
// ----------------------------------------------------------------------------
module swts_back #(
    parameter int WORD_LETTERS = swts_pkg::WORD_LETTERS_DEF,
    parameter int TABLE_DEPTH  = swts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  swts_pkg::swts_cmd_ctrl_t          cmd_ctrl,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    cmd_addr,
    input  logic [8*WORD_LETTERS-1:0]         cmd_key,
    output logic                              cmd_pop,
    input  logic                              count_we,
    input  logic [swts_pkg::COUNT_W-1:0]      count_data,
    output logic                              res_valid,
    output logic                              res_found,
    output logic [swts_pkg::INDEX_W-1:0]      res_index,
    input  logic                              res_pop
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int IW = AW + 2;
    localparam int WW = 8 * WORD_LETTERS;
    localparam int XW = swts_pkg::INDEX_W;

    logic [WW-1:0] mem [TABLE_DEPTH];
    logic [WW-1:0] rd_data_reg;

    swts_pkg::swts_state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic                 res_valid_reg, res_valid_next;
    logic [WW-1:0]        key_reg, key_next;
    logic signed [IW-1:0] lo_reg, lo_next;
    logic signed [IW-1:0] hi_reg, hi_next;
    logic [AW-1:0]        mid_reg, mid_next;
    logic                 pend_found_reg, pend_found_next;
    logic [XW-1:0]        pend_idx_reg, pend_idx_next;
    logic                 res_found_reg;
    logic [XW-1:0]        res_index_reg;

    logic                 wr_en, rd_en, res_load;
    logic                 cmp_lt, cmp_eq;
    logic signed [IW-1:0] mid_s, lo_upd, hi_upd, span, mid_calc;
    logic                 probe_go;
    logic [AW-1:0]        mid_addr;
    logic [31:0]          cnt32;
    logic [31:0]          mid32;

    always_comb
    begin
        cnt32      = 32'(count_data);
        count_next = (cnt32 > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt32[CW-1:0];
        mid32      = 32'(mid_reg);
    end

    // search bounds for the next probe
    always_comb
    begin
        cmp_lt = (key_reg < rd_data_reg);
        cmp_eq = (key_reg == rd_data_reg);
        mid_s  = $signed(IW'(mid_reg));
        case (state_reg)
            swts_pkg::ST_IDLE:
            begin
                lo_upd = '0;
                hi_upd = $signed({1'b0, count_reg}) - $signed(IW'(1));
            end
            swts_pkg::ST_CMP:
            begin
                lo_upd = cmp_lt ? lo_reg : mid_s + $signed(IW'(1));
                hi_upd = cmp_lt ? mid_s - $signed(IW'(1)) : hi_reg;
            end
            default:
            begin
                lo_upd = lo_reg;
                hi_upd = hi_reg;
            end
        endcase
        span     = hi_upd - lo_upd;
        mid_calc = hi_upd - (span >>> 1);
        probe_go = (lo_upd <= hi_upd);
        mid_addr = mid_calc[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swts_pkg::ST_IDLE:
            begin
                if (cmd_valid && cmd_ctrl.kind == swts_pkg::ACT_LOOKUP)
                begin
                    state_next = probe_go ? swts_pkg::ST_CMP : swts_pkg::ST_DONE;
                end
            end
            swts_pkg::ST_CMP:
            begin
                if (cmp_eq || !probe_go)
                begin
                    state_next = swts_pkg::ST_DONE;
                end
            end
            swts_pkg::ST_DONE:
            begin
                if (!res_valid_reg)
                begin
                    state_next = swts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop         = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        res_load        = 1'b0;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pend_found_next = pend_found_reg;
        pend_idx_next   = pend_idx_reg;
        case (state_reg)
            swts_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_ctrl.kind == swts_pkg::ACT_LOAD)
                    begin
                        wr_en = cmd_ctrl.addr_ok;
                    end
                    else
                    begin
                        key_next        = cmd_key;
                        lo_next         = lo_upd;
                        hi_next         = hi_upd;
                        rd_en           = probe_go;
                        mid_next        = mid_addr;
                        pend_found_next = 1'b0;
                        pend_idx_next   = '0;
                    end
                end
            end
            swts_pkg::ST_CMP:
            begin
                if (cmp_eq)
                begin
                    pend_found_next = 1'b1;
                    pend_idx_next   = mid32[XW-1:0];
                end
                else
                begin
                    lo_next  = lo_upd;
                    hi_next  = hi_upd;
                    rd_en    = probe_go;
                    mid_next = mid_addr;
                end
            end
            swts_pkg::ST_DONE:
            begin
                res_load = !res_valid_reg;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
        res_valid_next = (res_valid_reg && !res_pop) || res_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= swts_pkg::ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (count_we)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pend_found_reg <= pend_found_next;
        pend_idx_reg   <= pend_idx_next;
        if (res_load)
        begin
            res_found_reg <= pend_found_reg;
            res_index_reg <= pend_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cmd_addr] <= cmd_key;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[mid_addr];
        end
    end

    assign res_valid = res_valid_reg;
    assign res_found = res_found_reg;
    assign res_index = res_index_reg;

endmodule

>>> hw/rtl/sorted_word_table_search.sv
// ----------------------------------------------------------------------------
// sorted_word_table_search
// Sorted word table with binary search lookup.
// ----------------------------------------------------------------------------
// Input side is a queue: a word is taken when push is high and full is low.
// action 0 loads word into entry_index (indexes at or past the depth are
// dropped); action 1 looks the word up among entries 0..entry_count-1.
// Output side is a queue: found/match_index are valid while empty is low and
// leave on pop. Loads give no result word.
// entry_count is written through entry_count_we; the user must write it only
// while the block is idle (the block does not enforce it). A two-entry
// command queue sits between the front end and the search unit. A load
// writes the table from the idle state. A lookup starts its first probe from
// the idle state and makes one synchronous table read and compare per probe,
// at most clog2(TABLE_DEPTH)+1 probes. A finished result waits in the output
// register; while it waits, loads keep flowing and a following lookup holds
// in its last state until pop. Reset empties both queues and clears
// entry_count; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_word_table_search #(
    parameter int WORD_LETTERS = swts_pkg::WORD_LETTERS_DEF,
    parameter int TABLE_DEPTH  = swts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              action,
    input  logic [swts_pkg::INDEX_W-1:0]      entry_index,
    input  logic [8*WORD_LETTERS-1:0]         word,
    output logic                              empty,
    input  logic                              pop,
    output logic                              found,
    output logic [swts_pkg::INDEX_W-1:0]      match_index,
    input  logic                              entry_count_we,
    input  logic [swts_pkg::COUNT_W-1:0]      entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                      cmd_valid;
    logic                      cmd_pop;
    swts_pkg::swts_cmd_ctrl_t  cmd_ctrl;
    logic [AW-1:0]             cmd_addr;
    logic [8*WORD_LETTERS-1:0] cmd_key;
    logic                      res_valid;

    swts_front #(
        .WORD_LETTERS (WORD_LETTERS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .entry_index (entry_index),
        .word        (word),
        .cmd_valid   (cmd_valid),
        .cmd_ctrl    (cmd_ctrl),
        .cmd_addr    (cmd_addr),
        .cmd_key     (cmd_key),
        .cmd_pop     (cmd_pop)
    );

    swts_back #(
        .WORD_LETTERS (WORD_LETTERS),
        .TABLE_DEPTH  (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ctrl   (cmd_ctrl),
        .cmd_addr   (cmd_addr),
        .cmd_key    (cmd_key),
        .cmd_pop    (cmd_pop),
        .count_we   (entry_count_we),
        .count_data (entry_count),
        .res_valid  (res_valid),
        .res_found  (found),
        .res_index  (match_index),
        .res_pop    (pop)
    );

    assign empty = !res_valid;

endmodule
